[src/keyed_running_stats_table_core_defines.svh]
// Assertion macros for the keyed running stats table core
`ifndef KEYED_RUNNING_STATS_TABLE_CORE_DEFINES_SVH
`define KEYED_RUNNING_STATS_TABLE_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define KRS_ASSERT_IMPL(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("assertion failed");
`define KRS_ASSERT_NEXT(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
		else $error("assertion failed");
`else
`define KRS_ASSERT_IMPL(label, clk, rst_n, prop)
`define KRS_ASSERT_NEXT(label, clk, rst_n, a, b)
`endif
`endif

[src/krst_pkg.sv]
// ----------------------------------------------------------------------------
// krst_pkg
// Types and codes shared by the keyed running stats table core.
// ----------------------------------------------------------------------------
package krst_pkg;
	localparam logic [1:0] ACT_UPDATE = 2'd0;
	localparam logic [1:0] ACT_CLEAR  = 2'd1;
	localparam logic [1:0] ACT_READ   = 2'd2;

	localparam logic [2:0] ST_UPDATED  = 3'd0;
	localparam logic [2:0] ST_INSERTED = 3'd1;
	localparam logic [2:0] ST_FULL     = 3'd2;
	localparam logic [2:0] ST_CLEARED  = 3'd3;
	localparam logic [2:0] ST_RD_VALID = 3'd4;
	localparam logic [2:0] ST_RD_EMPTY = 3'd5;

	typedef enum logic [2:0] {
		S_IDLE, S_SEARCH, S_DIV, S_OUT
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic load;      // capture input word, reset search pointer
		logic step;      // test current slot, advance pointer
		logic div_start; // start mean division of result slot
		logic div_step;  // one quotient bit
		logic clear;     // empty table
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic hit;       // current slot matches or is free
		logic last;      // current slot is final slot to search
		logic none;      // no slot to search at all
		logic div_done;  // quotient complete
	} stat_t;
endpackage

[src/krst_stream_if.sv]
// ----------------------------------------------------------------------------
// krst_stream_if
// Valid/ready channel carrying one word of payload type.
// ----------------------------------------------------------------------------
interface krst_stream_if #(parameter int W = 8);
	logic         valid;
	logic         ready;
	logic [W-1:0] data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

[src/keyed_running_stats_table_core.sv]
// Sequence: an update searches slots, then divides for the mean; a full drop
// searches only; a read divides; a clear goes straight to the result.
// Throughput: one word at a time, the next accepted only once the result is
// accepted; the serial slot search and the 48-step restoring divider set it.
// Reset: arst_n clears all slot valid bits at once and sets key_limit to 16;
// slot contents stay undefined until written.
// ----------------------------------------------------------------------------
// keyed_running_stats_table_core
// Top level: configuration register, controller and datapath.
// ----------------------------------------------------------------------------
module keyed_running_stats_table_core #(
	parameter int NUM_SLOTS = 16,
	parameter int KEY_BITS  = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [4:0] cfg_wdata,
	krst_stream_if.sink   in_ch,
	krst_stream_if.source out_ch
);
	logic [4:0]      key_limit_q;
	krst_pkg::cmd_t  cmd;
	krst_pkg::stat_t stat;
	logic [2:0]  status;
	logic [15:0] entry_key;
	logic [3:0]  entry_slot;
	logic [31:0] last_s, min_s, max_s, mean_s, total_s;

	// hold key limit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) key_limit_q <= 5'd16;
		else if (cfg_we) key_limit_q <= cfg_wdata;
	end

	krst_ctrl u_ctrl (
		.clk, .arst_n,
		.in_valid(in_ch.valid), .in_ready(in_ch.ready),
		.in_action(in_ch.data[53:52]),
		.out_valid(out_ch.valid), .out_ready(out_ch.ready),
		.cmd, .stat
	);

	krst_datapath #(.NUM_SLOTS(NUM_SLOTS), .KEY_BITS(KEY_BITS)) u_dp (
		.clk, .arst_n, .cmd, .stat,
		.key_limit(key_limit_q),
		.in_action(in_ch.data[53:52]),
		.in_key(in_ch.data[51:36]),
		.in_sample(in_ch.data[35:4]),
		.in_rslot(in_ch.data[3:0]),
		.status, .entry_key, .entry_slot,
		.last_sample(last_s), .min_sample(min_s), .max_sample(max_s),
		.mean_sample(mean_s), .update_total(total_s)
	);

	assign out_ch.data = {status, entry_key, entry_slot, last_s, min_s, max_s, mean_s, total_s};
endmodule

[src/krst_datapath.sv]
// ----------------------------------------------------------------------------
// krst_datapath
// Slot table, serial search, restoring divider for the mean, result register.
// ----------------------------------------------------------------------------
`include "keyed_running_stats_table_core_defines.svh"
module krst_datapath #(
	parameter int NUM_SLOTS = 16,
	parameter int KEY_BITS  = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  krst_pkg::cmd_t   cmd,
	output krst_pkg::stat_t  stat,
	input  logic [4:0]       key_limit,
	input  logic [1:0]       in_action,
	input  logic [15:0]      in_key,
	input  logic [31:0]      in_sample,
	input  logic [3:0]       in_rslot,
	output logic [2:0]       status,
	output logic [15:0]      entry_key,
	output logic [3:0]       entry_slot,
	output logic [31:0]      last_sample,
	output logic [31:0]      min_sample,
	output logic [31:0]      max_sample,
	output logic [31:0]      mean_sample,
	output logic [31:0]      update_total
);
	localparam int IW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

	logic [NUM_SLOTS-1:0] valid_q;
	logic [KEY_BITS-1:0]  key_mem [NUM_SLOTS];
	logic [31:0]          last_mem [NUM_SLOTS];
	logic [31:0]          min_mem [NUM_SLOTS];
	logic [31:0]          max_mem [NUM_SLOTS];
	logic [47:0]          sum_mem [NUM_SLOTS];
	logic [31:0]          cnt_mem [NUM_SLOTS];

	logic [KEY_BITS-1:0] key_q;
	logic [31:0]         smp_q;
	logic [IW-1:0]       ptr_q;
	logic [IW-1:0]       ptr_nx;
	logic [8:0]          lim_q;

	// registered copy of the slot under test
	logic [KEY_BITS-1:0] key_rd_q;
	logic [31:0]         min_rd_q, max_rd_q, cnt_rd_q;
	logic [47:0]         sum_rd_q;

	// division state
	logic [47:0] rem_q, mag_q;
	logic [31:0] den_q;
	logic        neg_q;
	logic [5:0]  dcnt_q;

	logic [KEY_BITS-1:0] in_key_m;
	logic [31:0]         st_last, st_min, st_max, st_cnt;
	logic [47:0]         st_sum, smp_ext;
	logic                cur_valid, cur_match;
	logic [48:0]         trial;
	logic [31:0]         mean_v;
	logic [8:0]          ptr_ext;

	assign in_key_m  = KEY_BITS'(in_key);
	assign smp_ext   = {{16{smp_q[31]}}, smp_q};
	assign cur_valid = valid_q[ptr_q];
	assign cur_match = cur_valid && (key_rd_q == key_q);
	assign ptr_ext   = 9'(ptr_q);

	// next search pointer, also the fetch address
	always_comb begin
		if (cmd.load) ptr_nx = '0;
		else if (cmd.step && !stat.hit) ptr_nx = ptr_q + IW'(1);
		else ptr_nx = ptr_q;
	end

	// updated statistics of current slot
	always_comb begin
		if (cur_valid) begin
			st_last = smp_q;
			st_min  = ($signed(smp_q) < $signed(min_rd_q)) ? smp_q : min_rd_q;
			st_max  = ($signed(smp_q) > $signed(max_rd_q)) ? smp_q : max_rd_q;
			st_sum  = sum_rd_q + smp_ext;
			st_cnt  = (cnt_rd_q == 32'hFFFF_FFFF) ? cnt_rd_q : cnt_rd_q + 32'd1;
		end else begin
			st_last = smp_q;
			st_min  = smp_q;
			st_max  = smp_q;
			st_sum  = smp_ext;
			st_cnt  = 32'd1;
		end
	end

	assign stat.hit      = cur_match || !cur_valid;
	assign stat.last     = (ptr_ext + 9'd1 >= lim_q);
	assign stat.none     = (lim_q == 9'd0);
	assign stat.div_done = (dcnt_q == 6'd0);

	assign trial = {rem_q, mag_q[47]} - {17'd0, den_q};

	// saturate quotient to signed 32 bits; no count gives a zero mean
	always_comb begin
		if (den_q == 32'd0) begin
			mean_v = '0;
		end else if (neg_q) begin
			mean_v = (mag_q > 48'h8000_0000) ? 32'h8000_0000 : 32'(48'd0 - mag_q);
		end else begin
			mean_v = (mag_q > 48'h7FFF_FFFF) ? 32'h7FFF_FFFF : mag_q[31:0];
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			ptr_q   <= '0;
			dcnt_q  <= '0;
		end else begin
			ptr_q <= ptr_nx;
			if (cmd.clear) valid_q <= '0;
			if (cmd.step && stat.hit) valid_q[ptr_q] <= 1'b1;
			if (cmd.div_start) dcnt_q <= 6'd48;
			else if (cmd.div_step && dcnt_q != 6'd0) dcnt_q <= dcnt_q - 6'd1;
		end
	end

	// table storage, capture and result
	always_ff @(posedge clk) begin
		// fetch the slot that the search tests next
		key_rd_q <= key_mem[ptr_nx];
		min_rd_q <= min_mem[ptr_nx];
		max_rd_q <= max_mem[ptr_nx];
		sum_rd_q <= sum_mem[ptr_nx];
		cnt_rd_q <= cnt_mem[ptr_nx];
		if (cmd.load) begin
			key_q <= in_key_m;
			smp_q <= in_sample;
			lim_q <= (32'(key_limit) > NUM_SLOTS) ? 9'(NUM_SLOTS) : 9'(key_limit);
			mean_sample <= '0;
			case (in_action)
				krst_pkg::ACT_CLEAR: begin
					status       <= krst_pkg::ST_CLEARED;
					entry_key    <= '0;
					entry_slot   <= '0;
					last_sample  <= '0;
					min_sample   <= '0;
					max_sample   <= '0;
					update_total <= '0;
				end
				krst_pkg::ACT_READ: begin
					entry_slot <= in_rslot;
					if (32'(in_rslot) < NUM_SLOTS && valid_q[IW'(in_rslot)]) begin
						status <= krst_pkg::ST_RD_VALID;
						entry_key    <= 16'(key_mem[IW'(in_rslot)]);
						last_sample  <= last_mem[IW'(in_rslot)];
						min_sample   <= min_mem[IW'(in_rslot)];
						max_sample   <= max_mem[IW'(in_rslot)];
						update_total <= cnt_mem[IW'(in_rslot)];
						neg_q <= sum_mem[IW'(in_rslot)][47];
						mag_q <= sum_mem[IW'(in_rslot)][47] ?
							48'd0 - sum_mem[IW'(in_rslot)] : sum_mem[IW'(in_rslot)];
						den_q <= cnt_mem[IW'(in_rslot)];
					end else begin
						status       <= krst_pkg::ST_RD_EMPTY;
						entry_key    <= '0;
						last_sample  <= '0;
						min_sample   <= '0;
						max_sample   <= '0;
						update_total <= '0;
						den_q        <= '0;
					end
				end
				default: begin
					status       <= krst_pkg::ST_FULL;
					entry_key    <= 16'(in_key_m);
					entry_slot   <= '0;
					last_sample  <= '0;
					min_sample   <= '0;
					max_sample   <= '0;
					update_total <= '0;
				end
			endcase
		end
		if (cmd.step && stat.hit) begin
			key_mem[ptr_q]  <= key_q;
			last_mem[ptr_q] <= st_last;
			min_mem[ptr_q]  <= st_min;
			max_mem[ptr_q]  <= st_max;
			sum_mem[ptr_q]  <= st_sum;
			cnt_mem[ptr_q]  <= st_cnt;
			status       <= cur_valid ? krst_pkg::ST_UPDATED : krst_pkg::ST_INSERTED;
			entry_key    <= 16'(key_q);
			entry_slot   <= 4'(ptr_q);
			last_sample  <= st_last;
			min_sample   <= st_min;
			max_sample   <= st_max;
			update_total <= st_cnt;
			neg_q <= st_sum[47];
			mag_q <= st_sum[47] ? 48'd0 - st_sum : st_sum;
			den_q <= st_cnt;
		end
		if (cmd.div_start) rem_q <= '0;
		if (cmd.div_step && dcnt_q != 6'd0) begin
			if (!trial[48]) begin
				rem_q <= trial[47:0];
				mag_q <= {mag_q[46:0], 1'b1};
			end else begin
				rem_q <= {rem_q[46:0], mag_q[47]};
				mag_q <= {mag_q[46:0], 1'b0};
			end
		end
		if (cmd.div_step && dcnt_q == 6'd0) mean_sample <= mean_v;
	end

	`KRS_ASSERT_NEXT(a_clear_empties, clk, arst_n, cmd.clear, valid_q == '0)
	`KRS_ASSERT_IMPL(a_ptr_range, clk, arst_n, cmd.step |-> ptr_ext < lim_q)
	`KRS_ASSERT_IMPL(a_div_excl, clk, arst_n, !(cmd.div_start && cmd.step))
endmodule

[src/krst_ctrl.sv]
// ----------------------------------------------------------------------------
// krst_ctrl
// Sequencer: accept word, search slots, divide for mean, present result.
// ----------------------------------------------------------------------------
`include "keyed_running_stats_table_core_defines.svh"
module krst_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [1:0]       in_action,
	output logic             out_valid,
	input  logic             out_ready,
	output krst_pkg::cmd_t   cmd,
	input  krst_pkg::stat_t  stat
);
	krst_pkg::state_t state_q, state_d;
	logic             is_upd_q, is_upd_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= krst_pkg::S_IDLE;
			is_upd_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			is_upd_q <= is_upd_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d   = state_q;
		is_upd_d  = is_upd_q;
		cmd       = '0;
		in_ready  = 1'b0;
		out_valid = 1'b0;
		case (state_q)
			krst_pkg::S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					is_upd_d = 1'b0;
					case (in_action)
						krst_pkg::ACT_UPDATE: state_d = krst_pkg::S_SEARCH;
						krst_pkg::ACT_CLEAR: begin
							cmd.clear = 1'b1;
							state_d   = krst_pkg::S_OUT;
						end
						krst_pkg::ACT_READ: begin
							is_upd_d = 1'b1;
							state_d  = krst_pkg::S_DIV;
						end
						default: state_d = krst_pkg::S_IDLE;
					endcase
				end
			end
			krst_pkg::S_SEARCH: begin
				if (stat.none) begin
					state_d = krst_pkg::S_OUT;
				end else begin
					cmd.step = 1'b1;
					if (stat.hit) begin
						is_upd_d = 1'b1;
						state_d  = krst_pkg::S_DIV;
					end else if (stat.last) begin
						state_d = krst_pkg::S_OUT;
					end
				end
			end
			krst_pkg::S_DIV: begin
				if (is_upd_q) begin
					cmd.div_start = 1'b1;
					is_upd_d = 1'b0;
				end else begin
					cmd.div_step = 1'b1;
					if (stat.div_done) state_d = krst_pkg::S_OUT;
				end
			end
			krst_pkg::S_OUT: begin
				out_valid = 1'b1;
				if (out_ready) state_d = krst_pkg::S_IDLE;
			end
			default: state_d = krst_pkg::S_IDLE;
		endcase
	end

	`KRS_ASSERT_IMPL(a_hs_excl, clk, arst_n, !(in_ready && out_valid))
	`KRS_ASSERT_NEXT(a_out_done, clk, arst_n, out_valid && out_ready,
		state_q == krst_pkg::S_IDLE)
	`KRS_ASSERT_NEXT(a_clear_out, clk, arst_n, cmd.clear, out_valid)
endmodule

[sim/keyed_running_stats_table_core_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// keyed_running_stats_table_core_tb
// Self-checking bench: drives update, clear, read and no-op words under a range
// of key limits, predicts each result word and compares it as a whole word.
// ----------------------------------------------------------------------------
module keyed_running_stats_table_core_tb;
	localparam int NUM_SLOTS  = 16;
	localparam int KEY_BITS   = 16;
	localparam int IN_W       = 54;
	localparam int OUT_W      = 183;
	localparam int CYCLE_CAP  = 2000000;
	localparam int DRAIN_WAIT = 100;
	localparam logic [1:0] ACT_NONE = 2'd3;

	typedef struct packed {
		logic [1:0]         action;
		logic [15:0]        key_id;
		logic signed [31:0] sample_value;
		logic [3:0]         read_slot;
	} req_t;

	typedef struct packed {
		logic [2:0]         status;
		logic [15:0]        entry_key;
		logic [3:0]         entry_slot;
		logic signed [31:0] last_sample;
		logic signed [31:0] min_sample;
		logic signed [31:0] max_sample;
		logic signed [31:0] mean_sample;
		logic [31:0]        update_total;
	} rsp_t;

	logic       clk;
	logic       arst_n;
	logic       cfg_we;
	logic [4:0] cfg_wdata;

	krst_stream_if #(.W(IN_W))  in_ch ();
	krst_stream_if #(.W(OUT_W)) out_ch ();

	keyed_running_stats_table_core #(
		.NUM_SLOTS(NUM_SLOTS),
		.KEY_BITS (KEY_BITS)
	) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.in_ch    (in_ch.sink),
		.out_ch   (out_ch.source)
	);

	// shadow table
	logic [4:0]         lim_reg;
	logic               tbl_valid [NUM_SLOTS];
	logic [15:0]        tbl_key   [NUM_SLOTS];
	logic signed [31:0] tbl_last  [NUM_SLOTS];
	logic signed [31:0] tbl_min   [NUM_SLOTS];
	logic signed [31:0] tbl_max   [NUM_SLOTS];
	logic [47:0]        tbl_sum   [NUM_SLOTS];
	logic [31:0]        tbl_count [NUM_SLOTS];

	rsp_t pending_rsp [$];
	int   err_count;
	int   cycle_count;
	bit   idle_on;
	int   stall_left;

	// clock
	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_CAP) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	function automatic logic [31:0] mean_of(input logic [47:0] sum, input logic [31:0] cnt);
		logic        neg;
		logic [47:0] mag;
		logic [63:0] q;
		neg = sum[47];
		mag = neg ? (~sum + 48'd1) : sum;
		if (cnt == 0)
			return 32'd0;
		q = {16'd0, mag} / {32'd0, cnt};
		if (neg) begin
			if (q > 64'h8000_0000)
				q = 64'h8000_0000;
			return 32'd0 - q[31:0];
		end
		if (q > 64'h7FFF_FFFF)
			q = 64'h7FFF_FFFF;
		return q[31:0];
	endfunction

	function automatic rsp_t slot_report(input logic [2:0] st, input int s);
		rsp_t r;
		r.status       = st;
		r.entry_key    = tbl_key[s];
		r.entry_slot   = s[3:0];
		r.last_sample  = tbl_last[s];
		r.min_sample   = tbl_min[s];
		r.max_sample   = tbl_max[s];
		r.mean_sample  = mean_of(tbl_sum[s], tbl_count[s]);
		r.update_total = tbl_count[s];
		return r;
	endfunction

	// advance the shadow table by one word; returns 1 when a result follows
	function automatic bit apply_word(input req_t w, output rsp_t r);
		int lim;
		r = '0;
		lim = (lim_reg > NUM_SLOTS) ? NUM_SLOTS : lim_reg;
		case (w.action)
			krst_pkg::ACT_UPDATE: begin
				for (int s = 0; s < lim; s++) begin
					if (tbl_valid[s] && tbl_key[s] == w.key_id) begin
						tbl_last[s] = w.sample_value;
						if (tbl_max[s] < w.sample_value)
							tbl_max[s] = w.sample_value;
						if (w.sample_value < tbl_min[s])
							tbl_min[s] = w.sample_value;
						tbl_sum[s] = tbl_sum[s] + {{16{w.sample_value[31]}}, w.sample_value};
						if (tbl_count[s] != 32'hFFFF_FFFF)
							tbl_count[s] = tbl_count[s] + 1;
						r = slot_report(krst_pkg::ST_UPDATED, s);
						return 1'b1;
					end
					if (!tbl_valid[s]) begin
						tbl_valid[s] = 1'b1;
						tbl_key[s]   = w.key_id;
						tbl_last[s]  = w.sample_value;
						tbl_min[s]   = w.sample_value;
						tbl_max[s]   = w.sample_value;
						tbl_sum[s]   = {{16{w.sample_value[31]}}, w.sample_value};
						tbl_count[s] = 32'd1;
						r = slot_report(krst_pkg::ST_INSERTED, s);
						return 1'b1;
					end
				end
				r.status    = krst_pkg::ST_FULL;
				r.entry_key = w.key_id;
				return 1'b1;
			end
			krst_pkg::ACT_CLEAR: begin
				for (int s = 0; s < NUM_SLOTS; s++)
					tbl_valid[s] = 1'b0;
				r.status = krst_pkg::ST_CLEARED;
				return 1'b1;
			end
			krst_pkg::ACT_READ: begin
				if (tbl_valid[w.read_slot]) begin
					r = slot_report(krst_pkg::ST_RD_VALID, w.read_slot);
				end else begin
					r.status     = krst_pkg::ST_RD_EMPTY;
					r.entry_slot = w.read_slot;
				end
				return 1'b1;
			end
			default: return 1'b0;
		endcase
	endfunction

	// hand one word to the block and record its expected result
	task automatic send_word(input req_t w);
		rsp_t r;
		@(negedge clk);
		in_ch.valid = 1'b1;
		in_ch.data  = w;
		do
			@(posedge clk);
		while (!in_ch.ready);
		if (apply_word(w, r))
			pending_rsp.push_back(r);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			@(negedge clk);
			in_ch.valid = 1'b0;
			repeat ($urandom_range(0, 10)) @(negedge clk);
		end
	endtask

	task automatic send_op(input logic [1:0] act, input logic [15:0] key,
			input logic [31:0] val, input logic [3:0] slot);
		req_t w;
		w.action       = act;
		w.key_id       = key;
		w.sample_value = val;
		w.read_slot    = slot;
		send_word(w);
	endtask

	// hold until every result is back, then let the block settle
	task automatic wait_idle();
		@(negedge clk);
		in_ch.valid = 1'b0;
		while (pending_rsp.size() != 0)
			@(negedge clk);
		repeat (DRAIN_WAIT) @(negedge clk);
	endtask

	task automatic set_limit(input logic [4:0] v);
		wait_idle();
		cfg_we    = 1'b1;
		cfg_wdata = v;
		@(negedge clk);
		cfg_we  = 1'b0;
		lim_reg = v;
	endtask

	task automatic send_random(input int n, input int key_pool);
		req_t w;
		int   pick;
		for (int i = 0; i < n; i++) begin
			pick = $urandom_range(0, 99);
			w.key_id       = (key_pool == 0) ? 16'($urandom) : 16'($urandom_range(0, key_pool));
			w.sample_value = ($urandom_range(0, 3) == 0) ? $urandom
				: 32'($signed($urandom_range(0, 2000)) - 1000);
			w.read_slot    = 4'($urandom);
			if (pick < 70)
				w.action = krst_pkg::ACT_UPDATE;
			else if (pick < 92)
				w.action = krst_pkg::ACT_READ;
			else if (pick < 97)
				w.action = krst_pkg::ACT_CLEAR;
			else
				w.action = ACT_NONE;
			send_word(w);
		end
	endtask

	// check each result word against the oldest expectation
	always @(posedge clk) begin
		rsp_t got, want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			got = out_ch.data;
			if (pending_rsp.size() == 0) begin
				$display("%0t: unexpected result word %h", $time, got);
				err_count++;
			end else begin
				want = pending_rsp.pop_front();
				if (got !== want) begin
					$display("%0t: mismatch expected %h actual %h", $time, want, got);
					if (got.status !== want.status)
						$display("%0t:  status expected %0d actual %0d", $time,
							want.status, got.status);
					if (got.mean_sample !== want.mean_sample)
						$display("%0t:  mean expected %0d actual %0d", $time,
							want.mean_sample, got.mean_sample);
					err_count++;
				end
			end
		end
	end

	// result side stalls in bursts
	always @(negedge clk) begin
		if (stall_left > 0) begin
			stall_left--;
			out_ch.ready = 1'b0;
		end else if (idle_on && $urandom_range(0, 5) == 0) begin
			stall_left   = $urandom_range(0, 10);
			out_ch.ready = 1'b0;
		end else begin
			out_ch.ready = 1'b1;
		end
	end

	task automatic test_directed();
		send_op(krst_pkg::ACT_READ, 16'd0, 32'd0, 4'd0);
		send_op(krst_pkg::ACT_UPDATE, 16'hFFFF, 32'h7FFF_FFFF, 4'd0);
		send_op(krst_pkg::ACT_UPDATE, 16'hFFFF, 32'h8000_0000, 4'd0);
		send_op(krst_pkg::ACT_UPDATE, 16'hFFFF, 32'h8000_0000, 4'd0);
		send_op(krst_pkg::ACT_UPDATE, 16'h0000, 32'hFFFF_FFFF, 4'd0);
		send_op(krst_pkg::ACT_UPDATE, 16'h0000, 32'd3, 4'd0);
		send_op(krst_pkg::ACT_UPDATE, 16'h0000, 32'd0, 4'd0);
		send_op(krst_pkg::ACT_READ, 16'hFFFF, 32'hFFFF_FFFF, 4'd0);
		send_op(krst_pkg::ACT_READ, 16'd0, 32'd0, 4'd1);
		send_op(krst_pkg::ACT_READ, 16'd0, 32'd0, 4'd15);
		send_op(ACT_NONE, 16'h1234, 32'd5, 4'd1);
		for (int k = 0; k < 15; k++)
			send_op(krst_pkg::ACT_UPDATE, 16'(100 + k), 32'($signed(-k)), 4'd0);
		send_op(krst_pkg::ACT_UPDATE, 16'hBEEF, 32'd9, 4'd0);
		send_op(krst_pkg::ACT_READ, 16'd0, 32'd0, 4'd15);
		send_op(krst_pkg::ACT_CLEAR, 16'hFFFF, 32'hFFFF_FFFF, 4'hF);
		send_op(krst_pkg::ACT_READ, 16'd0, 32'd0, 4'd0);
	endtask

	task automatic test_limits();
		// limit zero drops every update
		set_limit(5'd0);
		send_op(krst_pkg::ACT_UPDATE, 16'h00AA, 32'd1, 4'd0);
		// limit one, then read a valid slot beyond a smaller limit
		set_limit(5'd1);
		send_op(krst_pkg::ACT_UPDATE, 16'h0001, 32'd10, 4'd0);
		send_op(krst_pkg::ACT_UPDATE, 16'h0002, 32'd20, 4'd0);
		set_limit(5'd16);
		send_op(krst_pkg::ACT_UPDATE, 16'h0002, 32'd20, 4'd0);
		set_limit(5'd1);
		send_op(krst_pkg::ACT_READ, 16'd0, 32'd0, 4'd1);
		// limit past the table size
		set_limit(5'd31);
		send_random(40, 24);
		set_limit(5'd10);
		send_random(40, 12);
		set_limit(5'd21);
	endtask

	task automatic test_random();
		set_limit(5'd16);
		send_random(400, 20);
		set_limit(5'd4);
		send_random(150, 6);
		set_limit(5'd16);
		send_random(100, 0);
		set_limit(5'd16);
		send_random(250, 15);
	endtask

	task automatic test_no_idle();
		wait_idle();
		idle_on = 1'b0;
		send_random(200, 18);
	endtask

	initial begin
		arst_n       = 1'b0;
		cfg_we       = 1'b0;
		cfg_wdata    = 5'd0;
		in_ch.valid  = 1'b0;
		in_ch.data   = '0;
		out_ch.ready = 1'b0;
		err_count    = 0;
		cycle_count  = 0;
		stall_left   = 0;
		idle_on      = 1'b1;
		lim_reg      = 5'd16;
		for (int s = 0; s < NUM_SLOTS; s++)
			tbl_valid[s] = 1'b0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed();
		test_limits();
		test_random();
		test_no_idle();

		wait_idle();
		if (err_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end
endmodule
